// ===== rtl/altbl_pkg.sv =====
// ----------------------------------------------------------------------------
// altbl_pkg: shared definitions of the array list table engine
// Sizes, action and status codes, cell command types and conversions.
// ----------------------------------------------------------------------------
package altbl_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 6;
  localparam int WORD_W  = 32;
  localparam int OIDX_W  = 5;

  typedef enum logic [2:0] {
    ACT_APPEND   = 3'd0,
    ACT_INSERT   = 3'd1,
    ACT_SEARCH   = 3'd2,
    ACT_MODIFY   = 3'd3,
    ACT_DELETE   = 3'd4,
    ACT_DUMP_FWD = 3'd5,
    ACT_DUMP_REV = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_BAD_POS   = 3'd3,
    STS_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_APPEND,
    CM_INSERT,
    CM_COMPARE,
    CM_MODIFY,
    CM_DELETE,
    CM_ROT_FWD,
    CM_ROT_REV
  } cell_mode_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_mode_e            mode;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] key;
  } cell_cmd_t;

  function automatic logic [DATA_WIDTH-1:0] to_elem(input logic [WORD_W-1:0] w);
    return DATA_WIDTH'(signed'(w));
  endfunction

  function automatic logic [WORD_W-1:0] to_word(input logic [DATA_WIDTH-1:0] e);
    return WORD_W'(signed'(e));
  endfunction

endpackage

// ===== rtl/altbl_cell.sv =====
// ----------------------------------------------------------------------------
// altbl_cell: one entry of the list chain
// Holds one element, loads it from its neighbors or the broadcast data as the
// command says, and keeps a registered match flag against the search key.
// ----------------------------------------------------------------------------
module altbl_cell
  import altbl_pkg::*;
(
  input  logic                  clk_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  cell_cmd_t             cmd_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  input  logic [DATA_WIDTH-1:0] head_i,
  input  logic [DATA_WIDTH-1:0] tail_i,
  input  logic                  first_i,
  input  logic                  after_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  match_q, match_d;
  logic [CNT_W-1:0]      my_idx;
  logic                  in_list, is_tail;

  always_comb begin
    my_idx  = CNT_W'(idx_i);
    in_list = my_idx < cmd_i.count;
    is_tail = (my_idx + CNT_W'(1)) == cmd_i.count;
    data_d  = data_q;
    match_d = match_q;
    unique case (cmd_i.mode)
      CM_APPEND: begin
        if (my_idx == cmd_i.count) data_d = cmd_i.wdata;
      end
      CM_INSERT: begin
        if (my_idx == cmd_i.pos) begin
          data_d = cmd_i.wdata;
        end else if (my_idx > cmd_i.pos && my_idx <= cmd_i.count) begin
          data_d = prev_i;
        end
      end
      CM_COMPARE: begin
        match_d = in_list && (data_q == cmd_i.key);
      end
      CM_MODIFY: begin
        if (first_i) data_d = cmd_i.wdata;
      end
      CM_DELETE: begin
        if (after_i && !is_tail && in_list) data_d = next_i;
      end
      CM_ROT_FWD: begin
        if (in_list) data_d = is_tail ? head_i : next_i;
      end
      CM_ROT_REV: begin
        if (in_list) data_d = (idx_i == '0) ? tail_i : prev_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ===== rtl/array_list_table_engine.sv =====
// ----------------------------------------------------------------------------
// array_list_table_engine: ordered list of signed words in a chain of cells
// Keeps up to DEPTH elements with a count and runs one action per command.
// ----------------------------------------------------------------------------
// A command is taken on a rising edge with start high and busy low. Each
// result appears for one cycle with out_valid_o high; the receiver cannot
// stall, so it must take every result as it comes.
// Append, insert, errors and the empty-list reply give their single result
// in the cycle after the command, and a new command may follow at once.
// Search, modify and delete pass through ST_APPLY: the cells compare the key
// in the command's cycle and register their match flags, then in ST_APPLY
// the first match is found by a prefix OR and the chain shifts or rewrites.
// busy is high in ST_APPLY and the result follows it.
// A dump streams one result per element, one per cycle. The chain rotates
// by one cell each cycle and the result is read at its head or tail, so
// after count steps the list is back in place. busy stays high until the
// last element has been read.
// Reset clears the count and the control state; element storage is not
// cleared, since no entry at or above the count is ever read.
// ----------------------------------------------------------------------------
module array_list_table_engine
  import altbl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           action_i,
  input  logic signed [31:0]   value_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic signed [31:0]   new_value_i,
  output logic                 out_valid_o,
  output logic signed [31:0]   data_o,
  output logic [OIDX_W-1:0]    index_o,
  output logic [2:0]           status_o,
  output logic                 last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_DUMP  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      step_q, step_d;
  logic [2:0]            act_q, act_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [DATA_WIDTH-1:0] newv_q, newv_d;

  logic                  res_valid_q, res_valid_d;
  logic [WORD_W-1:0]     res_data_q, res_data_d;
  logic [OIDX_W-1:0]     res_index_q, res_index_d;
  logic [2:0]            res_status_q, res_status_d;
  logic                  res_last_q, res_last_d;

  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      match_vec, hit_after, hit_first;
  logic [IDX_W-1:0]      hit_idx;
  logic                  found;
  logic [CNT_W-1:0]      cnt_m1;
  logic [DATA_WIDTH-1:0] tail_data;
  logic                  accept;
  logic                  dump_end;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign cnt_m1 = count_q - CNT_W'(1);
  assign tail_data = cell_data[cnt_m1[IDX_W-1:0]];

  // First match: inclusive prefix OR of the registered match flags.
  always_comb begin
    hit_after = match_vec;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      hit_after = hit_after | (hit_after << s);
    end
    hit_first = match_vec & ~(hit_after << 1);
    found     = hit_after[DEPTH-1];
    hit_idx   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_first[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_w, next_w;
      if (g == 0) begin : g_first
        assign prev_w = '0;
      end else begin : g_mid_prev
        assign prev_w = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign next_w = '0;
      end else begin : g_mid_next
        assign next_w = cell_data[g+1];
      end
      altbl_cell u_cell (
        .clk_i   (clk_i),
        .idx_i   (IDX_W'(g)),
        .cmd_i   (cmd),
        .prev_i  (prev_w),
        .next_i  (next_w),
        .head_i  (cell_data[0]),
        .tail_i  (tail_data),
        .first_i (hit_first[g]),
        .after_i (hit_after[g]),
        .data_o  (cell_data[g]),
        .match_o (match_vec[g])
      );
    end
  endgenerate

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    step_d       = step_q;
    act_d        = act_q;
    key_d        = key_q;
    newv_d       = newv_q;
    res_valid_d  = 1'b0;
    res_data_d   = res_data_q;
    res_index_d  = res_index_q;
    res_status_d = res_status_q;
    res_last_d   = 1'b1;
    dump_end     = 1'b0;
    cmd.mode     = CM_HOLD;
    cmd.count    = count_q;
    cmd.pos      = CNT_W'(position_i);
    cmd.wdata    = to_elem(value_i);
    cmd.key      = to_elem(value_i);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d        = action_i;
          key_d        = to_elem(value_i);
          newv_d       = to_elem(new_value_i);
          res_data_d   = to_word(to_elem(value_i));
          res_index_d  = '0;
          res_status_d = STS_OK;
          case (action_i)
            ACT_APPEND: begin
              res_valid_d = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                res_status_d = STS_FULL;
              end else begin
                cmd.mode    = CM_APPEND;
                count_d     = count_q + CNT_W'(1);
                res_index_d = OIDX_W'(count_q);
              end
            end
            ACT_INSERT: begin
              res_valid_d = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                res_status_d = STS_FULL;
              end else if (int'(position_i) > int'(count_q)) begin
                res_status_d = STS_BAD_POS;
              end else begin
                cmd.mode    = CM_INSERT;
                count_d     = count_q + CNT_W'(1);
                res_index_d = OIDX_W'(position_i);
              end
            end
            ACT_SEARCH, ACT_MODIFY, ACT_DELETE: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = STS_EMPTY;
              end else begin
                cmd.mode = CM_COMPARE;
                state_d  = ST_APPLY;
              end
            end
            ACT_DUMP_FWD, ACT_DUMP_REV: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = STS_EMPTY;
                res_data_d   = '0;
              end else begin
                step_d  = '0;
                state_d = ST_DUMP;
              end
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end
      ST_APPLY: begin
        state_d      = ST_IDLE;
        res_valid_d  = 1'b1;
        res_data_d   = to_word(key_q);
        res_index_d  = '0;
        res_status_d = STS_NOT_FOUND;
        cmd.wdata    = newv_q;
        if (found) begin
          res_status_d = STS_OK;
          res_index_d  = OIDX_W'(hit_idx);
          if (act_q == ACT_MODIFY) begin
            cmd.mode   = CM_MODIFY;
            res_data_d = to_word(newv_q);
          end else if (act_q == ACT_DELETE) begin
            cmd.mode = CM_DELETE;
            count_d  = cnt_m1;
          end
        end
      end
      ST_DUMP: begin
        dump_end     = (step_q == cnt_m1);
        res_valid_d  = 1'b1;
        res_status_d = STS_OK;
        res_last_d   = dump_end;
        if (act_q == ACT_DUMP_REV) begin
          cmd.mode    = CM_ROT_REV;
          res_data_d  = to_word(tail_data);
          res_index_d = OIDX_W'(cnt_m1 - step_q);
        end else begin
          cmd.mode    = CM_ROT_FWD;
          res_data_d  = to_word(cell_data[0]);
          res_index_d = OIDX_W'(step_q);
        end
        step_d = step_q + CNT_W'(1);
        if (dump_end) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      act_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      act_q       <= act_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    newv_q       <= newv_d;
    res_data_q   <= res_data_d;
    res_index_q  <= res_index_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign out_valid_o = res_valid_q;
  assign data_o      = signed'(res_data_q);
  assign index_o     = res_index_q;
  assign status_o    = res_status_q;
  assign last_o      = res_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("element count above table depth");

  a_apply_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_APPLY |=> state_q == ST_IDLE && out_valid_o)
    else $error("search cycle did not end with a result");

  a_mid_only_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> $past(state_q) == ST_DUMP)
    else $error("non-final result outside a dump");

  a_full_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_APPEND && count_q == CNT_W'(DEPTH)
    |=> out_valid_o && status_o == STS_FULL && $stable(count_q))
    else $error("append to a full list not rejected");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for array_list_table_engine
// Runs directed and random list actions, mirrors the list in a scoreboard
// and compares every result strobe against the predicted replies.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import altbl_pkg::*;

  typedef struct {
    logic [2:0]       act;
    logic [31:0]      value;
    logic [POS_W-1:0] pos;
    logic [31:0]      new_value;
    bit               wait_drain;
  } list_cmd_t;

  typedef struct {
    logic [31:0]       data;
    logic [OIDX_W-1:0] index;
    status_e           status;
    logic              last;
  } list_reply_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               action_i = '0;
  logic signed [31:0]       value_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [31:0]       new_value_i = '0;
  logic                     out_valid_o;
  logic signed [31:0]       data_o;
  logic [OIDX_W-1:0]        index_o;
  logic [2:0]               status_o;
  logic                     last_o;

  list_cmd_t   pending_items[$];
  list_reply_t expected_replies[$];

  // Scoreboard copy of the list.
  logic [DATA_WIDTH-1:0] shadow_elems [DEPTH];
  int                    shadow_count = 0;

  logic cmd_taken = 1'b0;
  int   accepted_count = 0;
  int   fail_count = 0;

  array_list_table_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .new_value_i (new_value_i),
    .out_valid_o (out_valid_o),
    .data_o      (data_o),
    .index_o     (index_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] elem_to_word(input logic [DATA_WIDTH-1:0] e);
    logic signed [DATA_WIDTH-1:0] se;
    se = e;
    return 32'(se);
  endfunction

  function automatic void push_reply(input logic [DATA_WIDTH-1:0] data, input int idx,
                                     input status_e status, input logic last);
    list_reply_t r;
    r.data   = elem_to_word(data);
    r.index  = OIDX_W'(idx);
    r.status = status;
    r.last   = last;
    expected_replies.push_back(r);
  endfunction

  function automatic void predict_list_action(input list_cmd_t c);
    logic signed [31:0]    sv;
    logic signed [31:0]    snv;
    logic [DATA_WIDTH-1:0] key;
    logic [DATA_WIDTH-1:0] repl;
    int                    at;
    int                    src;
    sv   = c.value;
    snv  = c.new_value;
    key  = DATA_WIDTH'(sv);
    repl = DATA_WIDTH'(snv);
    at   = -1;
    case (c.act)
      ACT_APPEND, ACT_INSERT: begin
        if (shadow_count >= DEPTH) begin
          push_reply(key, 0, STS_FULL, 1'b1);
        end else if (c.act == ACT_APPEND) begin
          shadow_elems[shadow_count] = key;
          push_reply(key, shadow_count, STS_OK, 1'b1);
          shadow_count++;
        end else if (int'(c.pos) > shadow_count) begin
          push_reply(key, 0, STS_BAD_POS, 1'b1);
        end else begin
          for (int i = shadow_count; i > int'(c.pos); i--) shadow_elems[i] = shadow_elems[i-1];
          shadow_elems[c.pos] = key;
          shadow_count++;
          push_reply(key, int'(c.pos), STS_OK, 1'b1);
        end
      end
      ACT_SEARCH, ACT_MODIFY, ACT_DELETE: begin
        for (int i = shadow_count - 1; i >= 0; i--) if (shadow_elems[i] == key) at = i;
        if (shadow_count == 0) begin
          push_reply(key, 0, STS_EMPTY, 1'b1);
        end else if (at < 0) begin
          push_reply(key, 0, STS_NOT_FOUND, 1'b1);
        end else if (c.act == ACT_SEARCH) begin
          push_reply(key, at, STS_OK, 1'b1);
        end else if (c.act == ACT_MODIFY) begin
          shadow_elems[at] = repl;
          push_reply(repl, at, STS_OK, 1'b1);
        end else begin
          for (int i = at; i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i+1];
          shadow_count--;
          push_reply(key, at, STS_OK, 1'b1);
        end
      end
      ACT_DUMP_FWD, ACT_DUMP_REV: begin
        if (shadow_count == 0) begin
          push_reply('0, 0, STS_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            src = (c.act == ACT_DUMP_FWD) ? i : shadow_count - 1 - i;
            push_reply(shadow_elems[src], src, STS_OK, (i + 1 == shadow_count));
          end
        end
      end
      default: ;  // The unused action code is dropped without a reply.
    endcase
  endfunction

  function automatic void add_cmd(input logic [2:0] act, input logic [31:0] value,
                                  input logic [POS_W-1:0] pos, input logic [31:0] nv);
    list_cmd_t c;
    c.act        = act;
    c.value      = value;
    c.pos        = pos;
    c.new_value  = nv;
    c.wait_drain = 1'b0;
    pending_items.push_back(c);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Sender: presents the next transaction once the current one is taken.
  always @(negedge clk_i) begin
    list_cmd_t next_cmd;
    bit        idle_ok;
    idle_ok = (accepted_count < 120) || (accepted_count >= 200);
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (pending_items.size() == 0) begin
        start <= 1'b0;
      end else if (pending_items[0].wait_drain && expected_replies.size() != 0) begin
        start <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 99) < 29) begin
        start <= 1'b0;
      end else begin
        next_cmd = pending_items.pop_front();
        start       <= 1'b1;
        action_i    <= next_cmd.act;
        value_i     <= next_cmd.value;
        position_i  <= next_cmd.pos;
        new_value_i <= next_cmd.new_value;
      end
    end
  end

  // Result check first, then the prediction for a transaction taken at this edge.
  always @(posedge clk_i) begin
    list_reply_t exp_r;
    list_cmd_t   seen;
    if (out_valid_o) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result: data %h index %0d status %0d last %b",
               data_o, index_o, status_o, last_o);
        fail_count++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (data_o !== exp_r.data) begin
          $error("data: expected %h, got %h", exp_r.data, data_o);
          fail_count++;
        end
        if (index_o !== exp_r.index) begin
          $error("index: expected %0d, got %0d", exp_r.index, index_o);
          fail_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          fail_count++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %b, got %b", exp_r.last, last_o);
          fail_count++;
        end
      end
    end
    cmd_taken <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      seen.act        = action_i;
      seen.value      = value_i;
      seen.pos        = position_i;
      seen.new_value  = new_value_i;
      seen.wait_drain = 1'b0;
      predict_list_action(seen);
      accepted_count++;
    end
  end

  initial begin
    logic [31:0] key_pool [6];
    logic [31:0] key;
    logic [31:0] nv;
    logic [2:0]  act;
    logic [POS_W-1:0] pos;
    int          made;
    int          roll;
    bit          grow;

    // Empty list cases first, including an out-of-range insert position.
    add_cmd(ACT_DUMP_FWD, 32'h1234_5678, '0, '0);
    add_cmd(ACT_DUMP_REV, 32'h0, '0, '0);
    add_cmd(ACT_SEARCH, 32'h7fff_ffff, '0, '0);
    add_cmd(ACT_MODIFY, 32'h8000_0000, '0, 32'h1);
    add_cmd(ACT_DELETE, 32'hffff_ffff, '0, '0);
    add_cmd(ACT_INSERT, 32'h5, 6'd1, '0);
    add_cmd(ACT_INSERT, 32'h5, 6'd63, '0);
    add_cmd(ACT_INSERT, 32'h8000_0000, 6'd0, '0);
    add_cmd(ACT_APPEND, 32'h7fff_ffff, 6'd63, 32'hffff_ffff);
    add_cmd(ACT_APPEND, 32'hffff_ffff, '0, '0);
    add_cmd(ACT_INSERT, 32'h0, 6'd3, '0);
    add_cmd(ACT_INSERT, 32'h2a, 6'd5, '0);
    add_cmd(ACT_SEARCH, 32'h8000_0000, '0, '0);
    add_cmd(ACT_SEARCH, 32'h0001_2345, '0, '0);
    add_cmd(ACT_MODIFY, 32'hffff_ffff, '0, 32'h7fff_ffff);
    add_cmd(ACT_SEARCH, 32'h7fff_ffff, '0, '0);
    add_cmd(3'd7, 32'hffff_ffff, 6'd63, 32'hffff_ffff);
    add_cmd(ACT_DUMP_FWD, '0, '0, '0);
    add_cmd(ACT_DUMP_REV, '0, '0, '0);
    add_cmd(ACT_DELETE, 32'h8000_0000, '0, '0);
    add_cmd(ACT_DELETE, 32'h5555_5555, '0, '0);
    add_cmd(ACT_DUMP_REV, '0, '0, '0);
    add_cmd(ACT_DUMP_FWD, '0, '0, '0);

    // Random part alternates growing and shrinking phases. Keys come mostly
    // from a small pool so that searches and deletes actually hit.
    made = 0;
    grow = 1'b0;
    while (made < 330) begin
      if (made % 45 == 0) begin
        grow = !grow;
        foreach (key_pool[k]) key_pool[k] = rand_word();
      end
      roll = $urandom_range(0, 99);
      key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 5)] : rand_word();
      nv   = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 5)] : rand_word();
      pos  = ($urandom_range(0, 99) < 70) ? POS_W'($urandom_range(0, 12))
                                          : POS_W'($urandom_range(0, 63));
      if (grow) begin
        if      (roll < 45) act = ACT_APPEND;
        else if (roll < 70) act = ACT_INSERT;
        else if (roll < 78) act = ACT_SEARCH;
        else if (roll < 86) act = ACT_MODIFY;
        else if (roll < 92) act = ACT_DELETE;
        else if (roll < 96) act = ACT_DUMP_FWD;
        else if (roll < 99) act = ACT_DUMP_REV;
        else                act = 3'd7;
      end else begin
        if      (roll < 15) act = ACT_APPEND;
        else if (roll < 25) act = ACT_INSERT;
        else if (roll < 35) act = ACT_SEARCH;
        else if (roll < 45) act = ACT_MODIFY;
        else if (roll < 85) act = ACT_DELETE;
        else if (roll < 92) act = ACT_DUMP_FWD;
        else if (roll < 99) act = ACT_DUMP_REV;
        else                act = 3'd7;
      end
      add_cmd(act, key, pos, nv);
      if (made == 165) pending_items[$].wait_drain = 1'b1;
      made++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || start) @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/altbl_pkg.sv
rtl/altbl_cell.sv
rtl/array_list_table_engine.sv
tb/tb.sv
